/* src/avt_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the STL vertex affine transform.
// Used by every module in src; depends on nothing.
package avt_pkg;

  localparam int NUM_REGS     = 6;
  localparam int NUM_COEFS    = 12;
  localparam int REG_W        = 64;
  localparam int CFG_IDX_W    = 3;
  localparam int CMDQ_DEPTH_DEF = 4;

  localparam int HEADER_BYTES = 80;
  localparam int COUNT_BYTES  = 4;
  localparam int NORMAL_BYTES = 12;
  localparam int VERTEX_BYTES = 12;
  localparam int ATTR_BYTES   = 2;

  localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [31:0] FP_QUIET_BIT   = 32'h0040_0000;
  localparam logic [7:0]  FP_EXP_MAX     = 8'hFF;

  localparam logic [NUM_REGS-1:0][REG_W-1:0] REG_RESET = {
    64'd1065353216,
    64'd0,
    64'd0,
    64'd4575657221408423936,
    64'd0,
    64'd1065353216
  };

  // One entry of the queue between the byte parser and the back end.
  typedef struct packed {
    logic        is_vertex;
    logic [7:0]  data;
    logic        last;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } avt_cmd_t;

  typedef struct packed {
    logic        start;
    logic        is_add;
    logic [31:0] a;
    logic [31:0] b;
  } avt_fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } avt_fpu_rsp_t;

  typedef logic [NUM_COEFS-1:0][31:0] avt_coefs_t;

endpackage

/* src/avt_front.sv */
`timescale 1ns / 1ps
// Byte parser: tracks the file layout and turns input bytes into queue entries.
// Depends on avt_pkg.
module avt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  output logic              cmd_push,
  output avt_pkg::avt_cmd_t cmd
);
  import avt_pkg::*;

  typedef enum logic [2:0] {PH_HEADER, PH_COUNT, PH_NORMAL, PH_VERTEX, PH_ATTR} phase_t;

  phase_t            phase, phase_next;
  logic [6:0]        byte_pos, byte_pos_next;
  logic [31:0]       tri_left, tri_left_next;
  logic [1:0]        vtx_num, vtx_num_next;
  logic [2:0][31:0]  vbuf, vbuf_next;

  always_comb begin
    phase_next    = phase;
    byte_pos_next = byte_pos;
    tri_left_next = tri_left;
    vtx_num_next  = vtx_num;
    vbuf_next     = vbuf;
    cmd_push      = 1'b0;
    cmd           = '0;
    if (accept) begin
      byte_pos_next = byte_pos + 7'd1;
      unique case (phase)
        PH_HEADER: begin
          cmd_push = 1'b1;
          if (byte_pos == 7'(HEADER_BYTES - 1)) begin
            byte_pos_next = '0;
            tri_left_next = '0;
            phase_next    = PH_COUNT;
          end
        end
        PH_COUNT: begin
          tri_left_next = tri_left | ({24'd0, in_byte} << {byte_pos[1:0], 3'b000});
          cmd_push = 1'b1;
          cmd.data = in_byte;
          if (byte_pos == 7'(COUNT_BYTES - 1)) begin
            byte_pos_next = '0;
            if (tri_left_next == '0) begin
              cmd.last   = 1'b1;
              phase_next = PH_HEADER;
            end else begin
              phase_next = PH_NORMAL;
            end
          end
        end
        PH_NORMAL: begin
          cmd_push = 1'b1;
          cmd.data = in_byte;
          if (byte_pos == 7'(NORMAL_BYTES - 1)) begin
            byte_pos_next = '0;
            vtx_num_next  = '0;
            phase_next    = PH_VERTEX;
          end
        end
        PH_VERTEX: begin
          vbuf_next[byte_pos[3:2]][{byte_pos[1:0], 3'b000} +: 8] = in_byte;
          if (byte_pos == 7'(VERTEX_BYTES - 1)) begin
            cmd_push      = 1'b1;
            cmd.is_vertex = 1'b1;
            cmd.x         = vbuf[0];
            cmd.y         = vbuf[1];
            cmd.z         = {in_byte, vbuf[2][23:0]};
            byte_pos_next = '0;
            vtx_num_next  = vtx_num + 2'd1;
            if (vtx_num == 2'd2) begin
              vtx_num_next = '0;
              phase_next   = PH_ATTR;
            end
          end
        end
        PH_ATTR: begin
          cmd_push = 1'b1;
          if (byte_pos == 7'(ATTR_BYTES - 1)) begin
            byte_pos_next = '0;
            tri_left_next = tri_left - 32'd1;
            if (tri_left_next == '0) begin
              cmd.last   = 1'b1;
              phase_next = PH_HEADER;
            end else begin
              phase_next = PH_NORMAL;
            end
          end
        end
        default: phase_next = PH_HEADER;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    vbuf <= vbuf_next;
    if (rst) begin
      phase    <= PH_HEADER;
      byte_pos <= '0;
      tri_left <= '0;
      vtx_num  <= '0;
    end else begin
      phase    <= phase_next;
      byte_pos <= byte_pos_next;
      tri_left <= tri_left_next;
      vtx_num  <= vtx_num_next;
    end
  end

endmodule

/* src/avt_cmdq.sv */
`timescale 1ns / 1ps
// Small FIFO between the byte parser and the back end.
// Depends on avt_pkg for the entry type.
module avt_cmdq #(
  parameter int DEPTH = avt_pkg::CMDQ_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  avt_pkg::avt_cmd_t push_data,
  input  logic              pop,
  output avt_pkg::avt_cmd_t head,
  output logic              full,
  output logic              empty
);
  import avt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  avt_cmd_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign head    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

/* src/avt_fpu.sv */
`timescale 1ns / 1ps
// Shared binary32 multiply/add unit, one operation at a time, round to nearest even.
// Depends on avt_pkg.
module avt_fpu (
  input  logic                  clk,
  input  logic                  rst,
  input  avt_pkg::avt_fpu_req_t req,
  output avt_pkg::avt_fpu_rsp_t rsp
);
  import avt_pkg::*;

  localparam int WW = 50;

  typedef enum logic [2:0] {F_IDLE, F_PREP, F_MUL, F_ADD, F_NORM, F_RND} fstate_t;

  function automatic logic [3:0] lz8(input logic [7:0] v);
    logic [3:0] n;
    logic       hit;
    n   = 4'd8;
    hit = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n   = 4'(7 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  fstate_t            state;
  logic               is_add;
  logic [31:0]        a, b;
  logic               sgn, stk, sub;
  logic signed [10:0] e;
  logic [WW-1:0]      w, wa, wb;
  logic [23:0]        ma, mb;
  logic [47:0]        prod;
  logic               done;
  logic [31:0]        res;

  // Operand decode.
  logic [7:0]  ea_f, eb_f, ea_e, eb_e;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [23:0] a_m, b_m;
  logic        special;
  logic [31:0] special_res;
  // Addition alignment.
  logic        a_big;
  logic [7:0]  d, e_big;
  logic [23:0] m_big, m_small;
  logic [WW-1:0] wb_full, wb_align, lost_mask;
  // Normalization.
  logic signed [10:0] rdiff, emin1;
  logic [5:0]         ramt;
  logic [3:0]         lz, lamt;
  logic [WW-1:0]      rmask;
  // Rounding.
  logic        g, s_bit, inc;
  logic [24:0] m25;
  logic signed [10:0] e_r;
  logic [31:0] packed_res;

  always_comb begin
    ea_f   = a[30:23];
    eb_f   = b[30:23];
    a_nan  = (ea_f == FP_EXP_MAX) && (a[22:0] != '0);
    b_nan  = (eb_f == FP_EXP_MAX) && (b[22:0] != '0);
    a_inf  = (ea_f == FP_EXP_MAX) && (a[22:0] == '0);
    b_inf  = (eb_f == FP_EXP_MAX) && (b[22:0] == '0);
    a_zero = (a[30:0] == '0);
    b_zero = (b[30:0] == '0);
    a_m    = {ea_f != 8'd0, a[22:0]};
    b_m    = {eb_f != 8'd0, b[22:0]};
    ea_e   = (ea_f == 8'd0) ? 8'd1 : ea_f;
    eb_e   = (eb_f == 8'd0) ? 8'd1 : eb_f;
    prod   = ma * mb;

    special     = 1'b1;
    special_res = '0;
    if (a_nan) begin
      special_res = a | FP_QUIET_BIT;
    end else if (b_nan) begin
      special_res = b | FP_QUIET_BIT;
    end else if (!is_add) begin
      if (a_inf || b_inf) begin
        special_res = (a_zero || b_zero) ? FP_DEFAULT_NAN
                                         : {a[31] ^ b[31], FP_EXP_MAX, 23'd0};
      end else if (a_zero || b_zero) begin
        special_res = {a[31] ^ b[31], 31'd0};
      end else begin
        special = 1'b0;
      end
    end else begin
      if (a_inf && b_inf) begin
        special_res = (a[31] != b[31]) ? FP_DEFAULT_NAN : a;
      end else if (a_inf) begin
        special_res = a;
      end else if (b_inf) begin
        special_res = b;
      end else if (a_zero && b_zero) begin
        special_res = {a[31] & b[31], 31'd0};
      end else if (a_zero) begin
        special_res = b;
      end else if (b_zero) begin
        special_res = a;
      end else begin
        special = 1'b0;
      end
    end

    // The larger magnitude goes first; the smaller is shifted right with the
    // lost bits jammed into the lowest bit.
    a_big   = (a[30:0] >= b[30:0]);
    m_big   = a_big ? a_m : b_m;
    m_small = a_big ? b_m : a_m;
    e_big   = a_big ? ea_e : eb_e;
    d       = a_big ? (ea_e - eb_e) : (eb_e - ea_e);
    wb_full = {1'b0, m_small, 25'd0};
    if (d >= 8'(WW)) begin
      lost_mask = '1;
      wb_align  = WW'(1);
    end else begin
      lost_mask = (WW'(1) << d[5:0]) - WW'(1);
      wb_align  = (wb_full >> d[5:0]) | WW'(|(wb_full & lost_mask));
    end

    rdiff = 11'sd1 - e;
    ramt  = (rdiff > 11'sd63) ? 6'd63 : rdiff[5:0];
    rmask = (WW'(1) << ramt) - WW'(1);
    lz    = lz8(w[WW-1 -: 8]);
    emin1 = e - 11'sd1;
    lamt  = (emin1 < $signed({7'd0, lz})) ? emin1[3:0] : lz;

    g     = w[25];
    s_bit = (|w[24:0]) | stk;
    inc   = g & (s_bit | w[26]);
    m25   = {1'b0, w[49:26]} + 25'(inc);
    if (m25[24]) begin
      e_r        = e + 11'sd1;
      packed_res = {sgn, e_r[7:0], 23'd0};
    end else begin
      e_r        = e;
      packed_res = {sgn, m25[23] ? e[7:0] : 8'd0, m25[22:0]};
    end
    if (e_r >= 11'sd255) begin
      packed_res = {sgn, FP_EXP_MAX, 23'd0};
    end
    if (w == '0 && !stk) begin
      packed_res = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      done  <= 1'b0;
    end else begin
      // Completion pulses when a special case resolves or a result is rounded.
      done <= ((state == F_PREP) && special) || (state == F_RND);
      unique case (state)
        F_IDLE: begin
          if (req.start) begin
            a      <= req.a;
            b      <= req.b;
            is_add <= req.is_add;
            state  <= F_PREP;
          end
        end
        F_PREP: begin
          stk <= 1'b0;
          if (special) begin
            res   <= special_res;
            state <= F_IDLE;
          end else if (!is_add) begin
            sgn   <= a[31] ^ b[31];
            ma    <= a_m;
            mb    <= b_m;
            e     <= $signed({3'd0, ea_e}) + $signed({3'd0, eb_e}) - 11'sd126;
            state <= F_MUL;
          end else begin
            sgn   <= a_big ? a[31] : b[31];
            sub   <= a[31] ^ b[31];
            wa    <= {1'b0, m_big, 25'd0};
            wb    <= wb_align;
            e     <= $signed({3'd0, e_big}) + 11'sd1;
            state <= F_ADD;
          end
        end
        F_MUL: begin
          w     <= {prod, 2'b00};
          state <= F_NORM;
        end
        F_ADD: begin
          w     <= sub ? (wa - wb) : (wa + wb);
          state <= F_NORM;
        end
        F_NORM: begin
          if (e < 11'sd1) begin
            stk <= stk | (|(w & rmask));
            w   <= w >> ramt;
            e   <= 11'sd1;
          end else if (!w[WW-1] && e > 11'sd1 && w != '0) begin
            w <= w << lamt;
            e <= e - $signed({7'd0, lamt});
          end else begin
            state <= F_RND;
          end
        end
        F_RND: begin
          res   <= packed_res;
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign rsp.done   = done;
  assign rsp.result = res;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> state == F_IDLE)
    else $error("operation started while the unit is busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("completion held for more than one cycle");

  a_norm_ok: assert property (@(posedge clk) disable iff (rst)
    state == F_RND |-> (w[WW-1] || e == 11'sd1 || w == '0))
    else $error("rounding an unnormalized mantissa");

endmodule

/* src/avt_back.sv */
`timescale 1ns / 1ps
// Back end: forwards byte entries and runs the vertex transform on the shared FPU.
// Depends on avt_pkg and avt_fpu.
module avt_back (
  input  logic               clk,
  input  logic               rst,
  input  avt_pkg::avt_coefs_t coefs,
  input  avt_pkg::avt_cmd_t  head,
  input  logic               q_empty,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output logic [7:0]         out_byte,
  output logic               last
);
  import avt_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_ISSUE, B_WAIT, B_EMIT} bstate_t;

  localparam logic [2:0] STEP_MUL_X  = 3'd0;
  localparam logic [2:0] STEP_MUL_Y  = 3'd1;
  localparam logic [2:0] STEP_ADD_XY = 3'd2;
  localparam logic [2:0] STEP_MUL_Z  = 3'd3;
  localparam logic [2:0] STEP_ADD_Z  = 3'd4;
  localparam logic [2:0] STEP_ADD_OF = 3'd5;

  bstate_t      state;
  logic [31:0]  x, y, z, acc, tmp;
  logic [95:0]  res_sr;
  logic [1:0]   row;
  logic [2:0]   step;
  logic [3:0]   cnt;
  logic         ovalid;
  logic         free, load_byte, load_out;
  avt_fpu_req_t req;
  avt_fpu_rsp_t rsp;

  assign free      = !ovalid || pop;
  assign q_pop     = (state == B_IDLE) && !q_empty && (head.is_vertex || free);
  assign load_byte = (state == B_IDLE) && !q_empty && !head.is_vertex && free;
  assign load_out  = load_byte || ((state == B_EMIT) && free);
  assign empty     = !ovalid;

  always_comb begin
    req       = '0;
    req.start = (state == B_ISSUE);
    unique case (step)
      STEP_MUL_X: begin
        req.a = coefs[{row, 2'd0}];
        req.b = x;
      end
      STEP_MUL_Y: begin
        req.a = coefs[{row, 2'd1}];
        req.b = y;
      end
      STEP_ADD_XY, STEP_ADD_Z: begin
        req.is_add = 1'b1;
        req.a      = acc;
        req.b      = tmp;
      end
      STEP_MUL_Z: begin
        req.a = coefs[{row, 2'd2}];
        req.b = z;
      end
      STEP_ADD_OF: begin
        req.is_add = 1'b1;
        req.a      = acc;
        req.b      = coefs[{row, 2'd3}];
      end
      default: req.start = 1'b0;
    endcase
  end

  avt_fpu u_fpu (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      ovalid <= 1'b0;
      row    <= '0;
      step   <= STEP_MUL_X;
      cnt    <= '0;
    end else begin
      // A new byte may replace the one taken in the same cycle.
      if (load_out) begin
        ovalid <= 1'b1;
      end else if (pop && ovalid) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (load_byte) begin
            out_byte <= head.data;
            last     <= head.last;
          end else if (q_pop) begin
            x     <= head.x;
            y     <= head.y;
            z     <= head.z;
            row   <= '0;
            step  <= STEP_MUL_X;
            state <= B_ISSUE;
          end
        end
        B_ISSUE: state <= B_WAIT;
        B_WAIT: begin
          if (rsp.done) begin
            unique case (step)
              STEP_MUL_X, STEP_ADD_XY, STEP_ADD_Z: begin
                acc   <= rsp.result;
                step  <= step + 3'd1;
                state <= B_ISSUE;
              end
              STEP_MUL_Y, STEP_MUL_Z: begin
                tmp   <= rsp.result;
                step  <= step + 3'd1;
                state <= B_ISSUE;
              end
              default: begin
                res_sr <= {rsp.result, res_sr[95:32]};
                step   <= STEP_MUL_X;
                row    <= row + 2'd1;
                if (row == 2'd2) begin
                  cnt   <= '0;
                  state <= B_EMIT;
                end else begin
                  state <= B_ISSUE;
                end
              end
            endcase
          end
        end
        B_EMIT: begin
          if (free) begin
            out_byte <= res_sr[7:0];
            last     <= 1'b0;
            res_sr   <= {8'd0, res_sr[95:8]};
            cnt      <= cnt + 4'd1;
            if (cnt == 4'(VERTEX_BYTES - 1)) begin
              state <= B_IDLE;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

/* src/stl_affine_vertex_transform.sv */
`timescale 1ns / 1ps
// Top level of the binary STL vertex affine transform.
// Depends on avt_pkg, avt_front, avt_cmdq and avt_back.
//
// Usage: the input file is fed one byte per request on in_byte with push;
// full stalls the sender. The rewritten file leaves one byte per request on
// out_byte/last while empty is low, taken with pop; last marks the final byte,
// after which the block expects the header of the next file.
// Header bytes come out as zero, the triangle count and the normals are
// copied, each vertex is replaced by m*v + offset in binary32 (round to
// nearest even, no fused operations) and the attribute bytes come out as zero.
// A copied or zeroed byte passes through the command queue and the output
// register. A vertex is worked on the single shared multiply/add unit as 18
// operations (normalization shifts left up to eight bits per cycle), then
// its 12 bytes flow out one per cycle while the receiver pops. Plain bytes
// go through at one per cycle while no vertex or stalled receiver holds
// them; the command queue (CMDQ_DEPTH entries) lets the parser keep taking
// bytes while a vertex is worked on. A stalled receiver holds the output
// register; the queue then fills and full rises. Reset returns the parser
// to the header and loads the identity matrix into the coefficient registers;
// cfg writes take effect at once, so they belong where no vertex is in flight.
module stl_affine_vertex_transform #(
  parameter int CMDQ_DEPTH = avt_pkg::CMDQ_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    in_byte,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    out_byte,
  output logic                          last,
  input  logic                          cfg_we,
  input  logic [avt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [avt_pkg::REG_W-1:0]     cfg_data
);
  import avt_pkg::*;

  logic [NUM_REGS-1:0][REG_W-1:0] regs;
  avt_coefs_t coefs;
  avt_cmd_t   cmd, head;
  logic       accept, cmd_push, q_empty, q_pop;

  // Writes to indexes past the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= REG_RESET;
    end else if (cfg_we && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  // Each register holds an even coefficient low and the next odd one high.
  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      coefs[2*i]     = regs[i][31:0];
      coefs[2*i + 1] = regs[i][63:32];
    end
  end

  assign accept = push && !full;

  avt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_byte  (in_byte),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  avt_cmdq #(
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd),
    .pop       (q_pop),
    .head      (head),
    .full      (full),
    .empty     (q_empty)
  );

  avt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .coefs    (coefs),
    .head     (head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_byte (out_byte),
    .last     (last)
  );

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for stl_affine_vertex_transform.
// Depends on avt_pkg and the RTL under src; it needs no other file.
//
// Whole binary STL files are queued as requests for a clocked driver. The
// driver pushes them in random bursts. A clocked monitor pops the rewritten
// bytes under a random stall pattern. Every accepted input byte runs through
// a local byte parser and a bit-exact binary32 multiply/add. The expected
// output bytes wait in a queue and are compared with what comes out.
module tb;
  import avt_pkg::*;

  // Clock, reset and the ports of the block.
  logic clk;
  logic rst;
  logic push;
  logic full;
  logic [7:0] in_byte;
  logic empty;
  logic pop;
  logic [7:0] out_byte;
  logic last;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0] cfg_data;

  // One output request of the block: a byte and its end-of-file mark.
  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } out_byte_t;

  // Parser phases of the local copy of the block.
  typedef enum logic [2:0] {
    PH_HEADER, PH_COUNT, PH_NORMAL, PH_VERTEX, PH_ATTR
  } stl_phase_t;

  logic [7:0] file_bytes[$];   // Bytes that wait to be pushed.
  out_byte_t  rewritten_q[$];  // Output bytes that the block still owes.

  // Local state of the file parser and of the coefficient registers.
  logic [REG_W-1:0] coef_regs[NUM_REGS];
  stl_phase_t       cur_phase;
  int               pos_in_phase;
  logic [31:0]      tris_left;
  int               vertex_idx;
  logic [31:0]      vtx_words[3];

  int errors;
  int bytes_in;
  int bytes_out;
  int vertices_done;
  int files_sent;

  // Sender bursts and receiver stalls.
  int  burst_left;
  int  gap_left;
  int  rx_cycle;
  int  rx_mode;
  bit  hold_go;
  bit  hold_done;
  int  hold_cnt;

  stl_affine_vertex_transform i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_byte   (in_byte),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .last      (last),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------------
  // Binary32 arithmetic, round to nearest even.
  // ---------------------------------------------------------------------

  function automatic bit is_nan(input logic [31:0] a);
    return (a[30:23] == FP_EXP_MAX) && (a[22:0] != 0);
  endfunction

  function automatic bit is_inf(input logic [31:0] a);
    return (a[30:23] == FP_EXP_MAX) && (a[22:0] == 0);
  endfunction

  // Splits a finite value into an integer significand and the weight of its lsb.
  function automatic void split_float(input logic [31:0] a, output logic [65:0] m,
                                      output int e);
    if (a[30:23] == 0) begin
      m = {43'd0, a[22:0]};
      e = -149;
    end else begin
      m = {42'd0, 1'b1, a[22:0]};
      e = int'(a[30:23]) - 150;
    end
  endfunction

  // Rounds the exact value m * 2^e (plus a sticky fraction below bit 0) to binary32.
  function automatic logic [31:0] round_float(input bit s, input int e, input logic [65:0] m,
                                              input bit stk);
    int msb;
    int sh;
    int lsb_exp;
    int field;
    logic [65:0] kept;
    logic [65:0] rem;
    bit g;
    msb = -1;
    for (int i = 0; i < 66; i++) begin
      if (m[i]) msb = i;
    end
    if (msb < 0) return {s, 31'd0};
    sh = msb - 23;
    // Below the smallest normal exponent the lsb is pinned at 2^-149.
    if (-149 - e > sh) sh = -149 - e;
    g = 1'b0;
    if (sh > 66) begin
      kept = '0;
      stk = 1'b1;
    end else if (sh > 0) begin
      kept = m >> sh;
      g = m[sh-1];
      rem = m & ((66'd1 << (sh - 1)) - 66'd1);
      stk = stk | (rem != 0);
    end else begin
      kept = m << (-sh);
    end
    lsb_exp = e + sh;
    if (g && (stk || kept[0])) kept = kept + 66'd1;
    if (kept[24]) begin
      kept = kept >> 1;
      lsb_exp++;
    end
    if (!kept[23]) return {s, 8'h00, kept[22:0]};
    field = lsb_exp + 150;
    if (field >= 255) return {s, FP_EXP_MAX, 23'd0};
    return {s, field[7:0], kept[22:0]};
  endfunction

  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic [65:0] ma;
    logic [65:0] mb;
    int ea;
    int eb;
    bit s;
    s = a[31] ^ b[31];
    if (is_nan(a)) return a | FP_QUIET_BIT;
    if (is_nan(b)) return b | FP_QUIET_BIT;
    if (is_inf(a) || is_inf(b)) begin
      // Infinity times zero is invalid.
      if (a[30:0] == 0 || b[30:0] == 0) return FP_DEFAULT_NAN;
      return {s, FP_EXP_MAX, 23'd0};
    end
    split_float(a, ma, ea);
    split_float(b, mb, eb);
    return round_float(s, ea + eb, ma * mb, 1'b0);
  endfunction

  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] big;
    logic [31:0] sml;
    logic [65:0] m1;
    logic [65:0] m2;
    logic [65:0] sum;
    int e1;
    int e2;
    int e;
    int sh2;
    bit stk;
    if (is_nan(a)) return a | FP_QUIET_BIT;
    if (is_nan(b)) return b | FP_QUIET_BIT;
    if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? FP_DEFAULT_NAN : a;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    split_float(big, m1, e1);
    split_float(sml, m2, e2);
    // Forty guard bits under the larger operand keep the sum exact enough to round.
    e = (e1 - 40 > e2) ? e1 - 40 : e2;
    m1 = m1 << (e1 - e);
    sh2 = e - e2;
    stk = 1'b0;
    if (sh2 >= 66) begin
      stk = (m2 != 0);
      m2 = '0;
    end else if (sh2 > 0) begin
      stk = ((m2 & ((66'd1 << sh2) - 66'd1)) != 0);
      m2 = m2 >> sh2;
    end
    if (big[31] == sml[31]) begin
      sum = m1 + m2;
    end else begin
      // A truncated subtrahend borrows one more; the sticky bit stays set.
      sum = m1 - m2 - {65'd0, stk};
    end
    if (sum == 0 && !stk) return {big[31] & sml[31], 31'd0};
    return round_float(big[31], e, sum, stk);
  endfunction

  // ---------------------------------------------------------------------
  // File parser and transform of the block.
  // ---------------------------------------------------------------------

  function automatic logic [31:0] coef_word(input int k);
    return k[0] ? coef_regs[k >> 1][63:32] : coef_regs[k >> 1][31:0];
  endfunction

  function automatic void expect_byte(input logic [7:0] data, input logic eof);
    out_byte_t r;
    r.data = data;
    r.eof = eof;
    rewritten_q = {rewritten_q, r};
  endfunction

  // Emits the 12 bytes of m * v + offset for the buffered vertex.
  function automatic void transform_vertex();
    logic [31:0] acc;
    for (int r = 0; r < 3; r++) begin
      acc = fadd(fmul(coef_word(4 * r), vtx_words[0]), fmul(coef_word(4 * r + 1), vtx_words[1]));
      acc = fadd(acc, fmul(coef_word(4 * r + 2), vtx_words[2]));
      acc = fadd(acc, coef_word(4 * r + 3));
      for (int i = 0; i < 4; i++) expect_byte(acc[8*i +: 8], 1'b0);
    end
  endfunction

  function automatic void rewrite_byte(input logic [7:0] b);
    case (cur_phase)
      PH_COUNT: begin
        tris_left[8*pos_in_phase +: 8] = b;
        pos_in_phase++;
        if (pos_in_phase >= COUNT_BYTES) begin
          pos_in_phase = 0;
          if (tris_left == 0) begin
            // An empty file ends on its last count byte.
            cur_phase = PH_HEADER;
            expect_byte(b, 1'b1);
            return;
          end
          cur_phase = PH_NORMAL;
        end
        expect_byte(b, 1'b0);
      end
      PH_NORMAL: begin
        pos_in_phase++;
        if (pos_in_phase >= NORMAL_BYTES) begin
          pos_in_phase = 0;
          vertex_idx = 0;
          cur_phase = PH_VERTEX;
        end
        expect_byte(b, 1'b0);
      end
      PH_VERTEX: begin
        vtx_words[pos_in_phase >> 2][8*(pos_in_phase & 3) +: 8] = b;
        pos_in_phase++;
        if (pos_in_phase >= VERTEX_BYTES) begin
          transform_vertex();
          vertices_done++;
          pos_in_phase = 0;
          vertex_idx++;
          if (vertex_idx >= 3) begin
            vertex_idx = 0;
            cur_phase = PH_ATTR;
          end
        end
      end
      PH_ATTR: begin
        pos_in_phase++;
        if (pos_in_phase >= ATTR_BYTES) begin
          pos_in_phase = 0;
          tris_left = tris_left - 1;
          if (tris_left == 0) begin
            cur_phase = PH_HEADER;
            expect_byte(8'h00, 1'b1);
            return;
          end
          cur_phase = PH_NORMAL;
        end
        expect_byte(8'h00, 1'b0);
      end
      default: begin
        pos_in_phase++;
        if (pos_in_phase >= HEADER_BYTES) begin
          pos_in_phase = 0;
          tris_left = '0;
          cur_phase = PH_COUNT;
        end
        expect_byte(8'h00, 1'b0);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------

  // Mixes special encodings, values near one and raw bit patterns.
  function automatic logic [31:0] pick_float();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 11))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return {v[31], 8'hFF, 23'd0};
      3: return {v[31], 8'hFF, v[22:0] | 23'd1};
      4: return {v[31], 8'h00, v[22:0]};
      5: return {v[31], 8'hFE, v[22:0]};
      6, 7: return v;
      default: return {v[31], 8'(124 + v[26:24]), v[22:0]};
    endcase
  endfunction

  task automatic add_byte(input logic [7:0] v);
    file_bytes = {file_bytes, v};
  endtask

  task automatic add_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) add_byte(w[8*i +: 8]);
  endtask

  // Queues a whole file. The vertices of the first triangle may be given.
  task automatic queue_file(input int ntri, input logic [31:0] first_tri[9], input bit fixed);
    for (int i = 0; i < HEADER_BYTES; i++) add_byte(8'($urandom));
    add_word(ntri);
    for (int t = 0; t < ntri; t++) begin
      for (int i = 0; i < NORMAL_BYTES; i++) add_byte(8'($urandom));
      for (int i = 0; i < 9; i++) add_word((fixed && t == 0) ? first_tri[i] : pick_float());
      for (int i = 0; i < ATTR_BYTES; i++) add_byte(8'($urandom));
    end
    files_sent++;
  endtask

  task automatic write_reg(input int idx, input logic [REG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx[CFG_IDX_W-1:0];
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx < NUM_REGS) coef_regs[idx] = val;
  endtask

  // Waits until every queued byte was taken and every owed byte came out,
  // then lets the slowest vertex in flight drain before registers change.
  task automatic wait_drained();
    while (file_bytes.size() != 0 || rewritten_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("ERROR %0t: %s got 0x%0h want 0x%0h (output byte %0d)",
             $realtime, what, got, want, bytes_out);
  endtask

  // ---------------------------------------------------------------------
  // Driver: offers the next queued byte in bursts with random gaps.
  // ---------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      push <= 1'b0;
    end else begin
      push <= (file_bytes.size() != 0);
      if (file_bytes.size() != 0) in_byte <= file_bytes[0];
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: stall pattern that rx_mode picks at random, plus one long hold.
  // ---------------------------------------------------------------------

  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 3);
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_go && !hold_done) begin
      // Keep the output blocked so the queue fills and full rises.
      pop <= 1'b0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt >= 400) hold_done <= 1'b1;
    end else begin
      case (rx_mode)
        0: pop <= 1'b1;
        1: pop <= ($urandom_range(0, 1) == 0);
        2: pop <= ($urandom_range(0, 4) == 0);
        default: pop <= (rx_cycle % 8 < 5);
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: predicts on every accepted input and checks every output.
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    out_byte_t want;
    if (!rst) begin
      if (push && !full) begin
        rewrite_byte(in_byte);
        void'(file_bytes.pop_front());
        bytes_in++;
      end
      if (pop && !empty) begin
        if (rewritten_q.size() == 0) begin
          report_mismatch("unexpected output byte", 32'(out_byte), 32'd0);
        end else begin
          want = rewritten_q.pop_front();
          if (out_byte !== want.data) begin
            report_mismatch("out_byte", 32'(out_byte), 32'(want.data));
          end
          if (last !== want.eof) report_mismatch("last", 32'(last), 32'(want.eof));
        end
        bytes_out++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------

  initial begin
    logic [31:0] tri_vals[9];
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    in_byte = 8'h00;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    bytes_in = 0;
    bytes_out = 0;
    vertices_done = 0;
    files_sent = 0;
    burst_left = 0;
    gap_left = 0;
    rx_cycle = 0;
    rx_mode = 0;
    hold_go = 1'b0;
    hold_done = 1'b0;
    hold_cnt = 0;
    for (int i = 0; i < NUM_REGS; i++) coef_regs[i] = REG_RESET[i];
    cur_phase = PH_HEADER;
    pos_in_phase = 0;
    tris_left = '0;
    vertex_idx = 0;
    for (int i = 0; i < 3; i++) vtx_words[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: an empty file, then one triangle with a negative zero,
    // positive infinity, quiet and signaling NaNs, the smallest subnormal and the
    // largest finite value, all under the identity matrix of reset.
    queue_file(0, tri_vals, 1'b0);
    tri_vals = '{32'h3F80_0000, 32'h4000_0000, 32'hC040_0000,
                 32'h7F80_0000, 32'h7FC0_0000, 32'h8000_0000,
                 32'h0000_0001, 32'h7F7F_FFFF, 32'hFF80_0001};
    queue_file(1, tri_vals, 1'b1);
    wait_drained();

    // A random matrix, with writes past the last register that must be
    // ignored, and one more triangle. The receiver blocks for a long stretch
    // while that file is offered.
    for (int r = 0; r < NUM_REGS; r++) write_reg(r, {pick_float(), pick_float()});
    write_reg(NUM_REGS, {REG_W{1'b1}});
    write_reg(NUM_REGS + 1, {REG_W{1'b1}});
    queue_file(1, tri_vals, 1'b0);
    hold_go = 1'b1;
    wait_drained();

    $display("Sent %0d files (%0d bytes) and checked %0d output bytes,",
             files_sent, bytes_in, bytes_out);
    $display("with %0d transformed vertices under the reset matrix and a random one.",
             vertices_done);
    if (errors == 0) begin
      $display("stl_affine_vertex_transform test passed");
    end else begin
      $display("stl_affine_vertex_transform test failed");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("Timeout with %0d output bytes still owed.", rewritten_q.size());
    $display("stl_affine_vertex_transform test failed");
    $finish;
  end

endmodule
